@@ rtl/core/pseudo_terminal_byte_channel_macros.svh @@
// assertion macros for the pseudo terminal byte channel
`ifndef PSEUDO_TERMINAL_BYTE_CHANNEL_MACROS_SVH
`define PSEUDO_TERMINAL_BYTE_CHANNEL_MACROS_SVH

`ifndef SYNTH
`define PTBC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PTBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PTBC_ASSERT(label, prop, msg)
`define PTBC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/core/ptbc_pkg.sv @@
package ptbc_pkg;

	localparam int unsigned FIFO_DEPTH = 4096;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned LEVEL_W    = 13;

	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);
	localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam int unsigned CFG_W     = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned OPENS_W   = 8;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_NL = 8'h0A;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MODE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERRUPT_CHAR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_QUIT_CHAR      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSPEND_CHAR   = 3'd5;

	// register reset values
	localparam logic       RST_SIGNAL_ENABLE  = 1'b1;
	localparam logic [2:0] RST_INPUT_MODE     = 3'd2;
	localparam logic [2:0] RST_OUTPUT_MODE    = 3'd3;
	localparam logic [7:0] RST_INTERRUPT_CHAR = 8'h03;
	localparam logic [7:0] RST_QUIT_CHAR      = 8'h1C;
	localparam logic [7:0] RST_SUSPEND_CHAR   = 8'h1A;

	typedef enum logic [2:0] {
		REQ_MASTER_WRITE = 3'd0,
		REQ_SLAVE_WRITE  = 3'd1,
		REQ_MASTER_READ  = 3'd2,
		REQ_SLAVE_READ   = 3'd3,
		REQ_SLAVE_OPEN   = 3'd4,
		REQ_SLAVE_CLOSE  = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_WOULD_BLOCK = 3'd1,
		ST_HUNG_UP     = 3'd2,
		ST_DROPPED     = 3'd3,
		ST_RETRY       = 3'd4,
		ST_CONSUMED    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		SIG_NONE = 2'd0,
		SIG_INT  = 2'd1,
		SIG_QUIT = 2'd2,
		SIG_STOP = 2'd3
	} sig_t;

	// classified operations handed from front to back
	typedef enum logic [3:0] {
		OP_NOP,
		OP_CONSUME,
		OP_PUSH_SLAVE,
		OP_PUSH_MASTER,
		OP_PUSH_MASTER2,
		OP_READ_MASTER,
		OP_READ_SLAVE,
		OP_OPEN,
		OP_CLOSE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		sig_t       sig;
		logic       last;
	} entry_t;

	typedef struct packed {
		logic [7:0]       rbyte;
		logic             rvalid;
		status_t          status;
		sig_t             sig;
		logic [CNT_W-1:0] ts_lvl;
		logic [CNT_W-1:0] tm_lvl;
		logic             hung;
		logic             last;
	} res_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_PUSH2,
		B_RD_TM,
		B_RD_TS
	} back_state_t;

endpackage

@@ rtl/core/ptbc_ram.sv @@
module ptbc_ram #(
	parameter int unsigned DEPTH  = 4096,
	parameter int unsigned WIDTH  = 8,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/ptbc_front.sv @@
module ptbc_front
	import ptbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [2:0]           req_type,
	input  logic [7:0]           data_byte,
	input  logic                 last_in_call,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 q_full,
	output logic                 q_push,
	output entry_t               q_entry
);

	logic       sig_en_q;
	logic [2:0] in_mode_q;
	logic [2:0] out_mode_q;
	logic [7:0] int_char_q;
	logic [7:0] quit_char_q;
	logic [7:0] susp_char_q;

	logic post;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_en_q    <= RST_SIGNAL_ENABLE;
			in_mode_q   <= RST_INPUT_MODE;
			out_mode_q  <= RST_OUTPUT_MODE;
			int_char_q  <= RST_INTERRUPT_CHAR;
			quit_char_q <= RST_QUIT_CHAR;
			susp_char_q <= RST_SUSPEND_CHAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIGNAL_ENABLE:  sig_en_q    <= cfg_data[0];
				CFG_INPUT_MODE:     in_mode_q   <= cfg_data[2:0];
				CFG_OUTPUT_MODE:    out_mode_q  <= cfg_data[2:0];
				CFG_INTERRUPT_CHAR: int_char_q  <= cfg_data[7:0];
				CFG_QUIT_CHAR:      quit_char_q <= cfg_data[7:0];
				CFG_SUSPEND_CHAR:   susp_char_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign q_push = in_valid && !q_full;
	assign post   = out_mode_q[0];

	// classify the request and apply the character translations
	always_comb begin
		q_entry.op   = OP_NOP;
		q_entry.data = data_byte;
		q_entry.sig  = SIG_NONE;
		q_entry.last = last_in_call;
		unique case (req_type)
			REQ_MASTER_WRITE: begin
				if (sig_en_q && data_byte == int_char_q) begin
					q_entry.sig = SIG_INT;
				end else if (sig_en_q && data_byte == quit_char_q) begin
					q_entry.sig = SIG_QUIT;
				end else if (sig_en_q && data_byte == susp_char_q) begin
					q_entry.sig = SIG_STOP;
				end
				if (q_entry.sig != SIG_NONE) begin
					q_entry.op = OP_CONSUME;
				end else if (data_byte == CHAR_CR && in_mode_q[0]) begin
					q_entry.op = OP_CONSUME;
				end else begin
					q_entry.op = OP_PUSH_SLAVE;
					if (data_byte == CHAR_CR && in_mode_q[1]) begin
						q_entry.data = CHAR_NL;
					end else if (data_byte == CHAR_NL && in_mode_q[2]) begin
						q_entry.data = CHAR_CR;
					end
				end
			end
			REQ_SLAVE_WRITE: begin
				if (data_byte == CHAR_NL && post && out_mode_q[1]) begin
					q_entry.op = OP_PUSH_MASTER2;
				end else begin
					q_entry.op = OP_PUSH_MASTER;
					if (data_byte == CHAR_CR && post && out_mode_q[2]) begin
						q_entry.data = CHAR_NL;
					end
				end
			end
			REQ_MASTER_READ: q_entry.op = OP_READ_MASTER;
			REQ_SLAVE_READ:  q_entry.op = OP_READ_SLAVE;
			REQ_SLAVE_OPEN:  q_entry.op = OP_OPEN;
			REQ_SLAVE_CLOSE: q_entry.op = OP_CLOSE;
			default:         q_entry.op = OP_NOP;
		endcase
	end

endmodule

@@ rtl/core/ptbc_queue.sv @@
module ptbc_queue
	import ptbc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   valid,
	output entry_t head
);

	entry_t             slot_q [Q_DEPTH];
	logic [QPTR_W-1:0]  wp_q;
	logic [QPTR_W-1:0]  rp_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == QCNT_W'(Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/ptbc_back.sv @@
`include "pseudo_terminal_byte_channel_macros.svh"

module ptbc_back
	import ptbc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	input  entry_t q_head,
	output logic   q_pop,
	input  logic   out_stall,
	output logic   out_valid,
	output res_t   res
);

	back_state_t state_q, state_n;

	logic [PTR_W-1:0]   ts_wp_q, ts_rp_q, ts_wp_n, ts_rp_n;
	logic [CNT_W-1:0]   ts_cnt_q, ts_cnt_n;
	logic [PTR_W-1:0]   tm_wp_q, tm_rp_q, tm_wp_n, tm_rp_n;
	logic [CNT_W-1:0]   tm_cnt_q, tm_cnt_n;
	logic [OPENS_W-1:0] opens_q, opens_n;
	logic               hang_q, hang_n;

	res_t pend_q;
	res_t out_q;
	logic out_valid_q;
	res_t res_n;
	logic load_out;
	logic load_pend;

	logic       ts_we, tm_we;
	logic [7:0] ts_wdata, tm_wdata;
	logic [7:0] ts_rdata, tm_rdata;

	logic exec;
	logic ts_room, tm_room, tm_room2, ts_any, tm_any;
	logic rd_finish;

	assign ts_room  = (ts_cnt_q != CNT_W'(FIFO_DEPTH));
	assign tm_room  = (tm_cnt_q != CNT_W'(FIFO_DEPTH));
	assign tm_room2 = (tm_cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign ts_any   = (ts_cnt_q != '0);
	assign tm_any   = (tm_cnt_q != '0);

	assign exec  = (state_q == B_IDLE) && q_valid && (!out_valid_q || !out_stall);
	assign q_pop = exec;

	// finishing state of a read
	assign rd_finish = (state_q == B_RD_TM) || (state_q == B_RD_TS);

	ptbc_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(8)) u_ts_ram (
		.clk   (clk),
		.we    (ts_we),
		.waddr (ts_wp_q),
		.wdata (ts_wdata),
		.raddr (ts_rp_q),
		.rdata (ts_rdata)
	);

	ptbc_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(8)) u_tm_ram (
		.clk   (clk),
		.we    (tm_we),
		.waddr (tm_wp_q),
		.wdata (tm_wdata),
		.raddr (tm_rp_q),
		.rdata (tm_rdata)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (exec) begin
					if (q_head.op == OP_PUSH_MASTER2 && tm_room2) begin
						state_n = B_PUSH2;
					end else if (q_head.op == OP_READ_MASTER && tm_any) begin
						state_n = B_RD_TM;
					end else if (q_head.op == OP_READ_SLAVE && ts_any) begin
						state_n = B_RD_TS;
					end
				end
			end
			B_PUSH2: state_n = B_IDLE;
			B_RD_TM: state_n = B_IDLE;
			B_RD_TS: state_n = B_IDLE;
			default: state_n = B_IDLE;
		endcase
	end

	// datapath actions and result
	always_comb begin
		ts_wp_n   = ts_wp_q;
		ts_rp_n   = ts_rp_q;
		ts_cnt_n  = ts_cnt_q;
		tm_wp_n   = tm_wp_q;
		tm_rp_n   = tm_rp_q;
		tm_cnt_n  = tm_cnt_q;
		opens_n   = opens_q;
		hang_n    = hang_q;
		ts_we     = 1'b0;
		tm_we     = 1'b0;
		ts_wdata  = q_head.data;
		tm_wdata  = q_head.data;
		load_out  = 1'b0;
		load_pend = 1'b0;

		res_n.rbyte  = '0;
		res_n.rvalid = 1'b0;
		res_n.status = ST_OK;
		res_n.sig    = SIG_NONE;
		res_n.last   = q_head.last;

		unique case (state_q)
			B_IDLE: begin
				if (exec) begin
					case (q_head.op)
						OP_CONSUME: begin
							res_n.status = ST_CONSUMED;
							res_n.sig    = q_head.sig;
							load_out     = 1'b1;
						end
						OP_PUSH_SLAVE: begin
							if (ts_room) begin
								ts_we    = 1'b1;
								ts_wp_n  = (ts_wp_q == PTR_W'(FIFO_DEPTH - 1)) ?
									'0 : ts_wp_q + 1'b1;
								ts_cnt_n = ts_cnt_q + 1'b1;
							end else begin
								res_n.status = ST_DROPPED;
							end
							load_out = 1'b1;
						end
						OP_PUSH_MASTER: begin
							if (tm_room) begin
								tm_we    = 1'b1;
								tm_wp_n  = (tm_wp_q == PTR_W'(FIFO_DEPTH - 1)) ?
									'0 : tm_wp_q + 1'b1;
								tm_cnt_n = tm_cnt_q + 1'b1;
							end else begin
								res_n.status = ST_RETRY;
							end
							load_out = 1'b1;
						end
						OP_PUSH_MASTER2: begin
							// cr now, nl in the following cycle
							if (tm_room2) begin
								tm_we     = 1'b1;
								tm_wdata  = CHAR_CR;
								tm_wp_n   = (tm_wp_q == PTR_W'(FIFO_DEPTH - 1)) ?
									'0 : tm_wp_q + 1'b1;
								tm_cnt_n  = tm_cnt_q + CNT_W'(2);
								load_pend = 1'b1;
							end else begin
								res_n.status = ST_RETRY;
								load_out     = 1'b1;
							end
						end
						OP_READ_MASTER: begin
							if (tm_any) begin
								tm_rp_n      = (tm_rp_q == PTR_W'(FIFO_DEPTH - 1)) ?
									'0 : tm_rp_q + 1'b1;
								tm_cnt_n     = tm_cnt_q - 1'b1;
								res_n.rvalid = 1'b1;
								load_pend    = 1'b1;
							end else begin
								res_n.status = hang_q ? ST_HUNG_UP : ST_WOULD_BLOCK;
								load_out     = 1'b1;
							end
						end
						OP_READ_SLAVE: begin
							if (ts_any) begin
								ts_rp_n      = (ts_rp_q == PTR_W'(FIFO_DEPTH - 1)) ?
									'0 : ts_rp_q + 1'b1;
								ts_cnt_n     = ts_cnt_q - 1'b1;
								res_n.rvalid = 1'b1;
								load_pend    = 1'b1;
							end else begin
								res_n.status = ST_WOULD_BLOCK;
								load_out     = 1'b1;
							end
						end
						OP_OPEN: begin
							if (opens_q != '1) begin
								opens_n = opens_q + 1'b1;
							end
							hang_n   = 1'b0;
							load_out = 1'b1;
						end
						OP_CLOSE: begin
							if (opens_q != '0) begin
								opens_n = opens_q - 1'b1;
							end
							if (opens_n == '0) begin
								hang_n = 1'b1;
							end
							load_out = 1'b1;
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			B_PUSH2: begin
				tm_we    = 1'b1;
				tm_wdata = CHAR_NL;
				tm_wp_n  = (tm_wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tm_wp_q + 1'b1;
				load_out = 1'b1;
			end
			B_RD_TM: load_out = 1'b1;
			B_RD_TS: load_out = 1'b1;
			default: ;
		endcase

		res_n.ts_lvl = ts_cnt_n;
		res_n.tm_lvl = tm_cnt_n;
		res_n.hung   = hang_n;

		// the finishing states B_PUSH2, B_RD_TM and B_RD_TS replay the held result, reads with the ring byte
		if (state_q == B_PUSH2) begin
			res_n = pend_q;
		end else if (state_q == B_RD_TM) begin
			res_n       = pend_q;
			res_n.rbyte = tm_rdata;
		end else if (state_q == B_RD_TS) begin
			res_n       = pend_q;
			res_n.rbyte = ts_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			ts_wp_q     <= '0;
			ts_rp_q     <= '0;
			ts_cnt_q    <= '0;
			tm_wp_q     <= '0;
			tm_rp_q     <= '0;
			tm_cnt_q    <= '0;
			opens_q     <= '0;
			hang_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			ts_wp_q  <= ts_wp_n;
			ts_rp_q  <= ts_rp_n;
			ts_cnt_q <= ts_cnt_n;
			tm_wp_q  <= tm_wp_n;
			tm_rp_q  <= tm_rp_n;
			tm_cnt_q <= tm_cnt_n;
			opens_q  <= opens_n;
			hang_q   <= hang_n;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_pend) begin
			pend_q <= res_n;
		end
		if (load_out) begin
			out_q <= res_n;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = out_q;

	`PTBC_ASSERT(a_ts_bound, ts_cnt_q <= CNT_W'(FIFO_DEPTH), "to-slave count past depth")
	`PTBC_ASSERT(a_tm_bound, tm_cnt_q <= CNT_W'(FIFO_DEPTH), "to-master count past depth")
	`PTBC_ASSERT(a_busy_no_pop, (state_q != B_IDLE) |-> !q_pop, "item taken while busy")
	`PTBC_ASSERT_NEXT(a_rd_result, rd_finish, out_valid_q && out_q.rvalid, "read result missing")

endmodule

@@ rtl/core/pseudo_terminal_byte_channel.sv @@
// channel | direction | handshake           | payload
// in      | into      | in_valid / in_stall  | req_type, data_byte, last_in_call
// out     | out of    | out_valid / out_stall| read_byte, read_valid, status, signal_code,
//         |           |                      | to_slave_level, to_master_level, hung_up,
//         |           |                      | call_done
// cfg     | into      | cfg_we               | cfg_index, cfg_data
//
// an item is classified on entry and lands in a two-entry queue; the back end
// executes it against the two byte rings once it reaches the queue head
// most items finish in the idle back-end state; reads and the nl to cr nl
// expansion add a finishing state, set by the registered read port and the
// single write port of each ring memory; the result passes the queue slot and
// the result register, and reads and the nl to cr nl expansion also pend_q
// reset clears pointers, counts, open count and hang-up flag; the ring memories
// are not cleared and need no clearing pass
// out_stall holds the result register and the back end; the queue then fills and
// raises in_stall
module pseudo_terminal_byte_channel
	import ptbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input items
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           req_type,
	input  logic [7:0]           data_byte,
	input  logic                 last_in_call,
	// result items
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           read_byte,
	output logic                 read_valid,
	output logic [2:0]           status,
	output logic [1:0]           signal_code,
	output logic [LEVEL_W-1:0]   to_slave_level,
	output logic [LEVEL_W-1:0]   to_master_level,
	output logic                 hung_up,
	output logic                 call_done,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// front to queue
	logic   q_full;
	logic   q_push;
	entry_t q_in;

	// queue to back
	logic   q_valid;
	logic   q_pop;
	entry_t q_head;

	res_t res;

	// signal detection and cr/nl translation, holds the config registers
	ptbc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.req_type     (req_type),
		.data_byte    (data_byte),
		.last_in_call (last_in_call),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_in)
	);

	assign in_stall = q_full;

	// decouples classification from execution
	ptbc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.valid      (q_valid),
		.head       (q_head)
	);

	// the two rings, open count and hang-up state
	ptbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res       (res)
	);

	// unpack the result item onto its ports
	assign read_byte       = res.rbyte;
	assign read_valid      = res.rvalid;
	assign status          = res.status;
	assign signal_code     = res.sig;
	assign to_slave_level  = LEVEL_W'(res.ts_lvl);
	assign to_master_level = LEVEL_W'(res.tm_lvl);
	assign hung_up         = res.hung;
	assign call_done       = res.last;

endmodule

@@ bench/tb_pseudo_terminal_byte_channel.sv @@
module tb_pseudo_terminal_byte_channel;
	import ptbc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// request codes the block treats as no-ops
	localparam logic [2:0] REQ_RESERVED_A = 3'd6;
	localparam logic [2:0] REQ_RESERVED_B = 3'd7;
	// register indexes past the last register, ignored by the block
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	// one result item as the output ports show it
	typedef struct packed {
		logic [7:0]         rbyte;
		logic               rvalid;
		logic [2:0]         status;
		logic [1:0]         sig;
		logic [LEVEL_W-1:0] ts_lvl;
		logic [LEVEL_W-1:0] tm_lvl;
		logic               hung;
		logic               last;
	} line_result_t;

	// hand-written expectation for a directed item, used when known is set
	typedef struct packed {
		logic       known;
		logic [2:0] status;
		logic [1:0] sig;
		logic       rvalid;
		logic [7:0] rbyte;
	} hand_check_t;

	typedef struct packed {
		logic [2:0]  req;
		logic [7:0]  data;
		logic        last;
		hand_check_t check;
	} directed_row_t;

	typedef struct packed {
		logic       sig_en;
		logic [2:0] in_mode;
		logic [2:0] out_mode;
		logic [7:0] intr_char;
		logic [7:0] quit_char;
		logic [7:0] susp_char;
	} line_setting_t;

	localparam hand_check_t NO_CHECK = '{1'b0, ST_OK, SIG_NONE, 1'b0, 8'h00};

	// directed items, all run with the register values from reset
	localparam directed_row_t DIRECTED_ROWS [25] = '{
		// empty reads before any open or close
		'{REQ_MASTER_READ,  8'h00, 1'b0, '{1'b1, ST_WOULD_BLOCK, SIG_NONE, 1'b0, 8'h00}},
		'{REQ_SLAVE_READ,   8'hFF, 1'b1, '{1'b1, ST_WOULD_BLOCK, SIG_NONE, 1'b0, 8'h00}},
		// close with no opener sets hang-up, master read then reports it
		'{REQ_SLAVE_CLOSE,  8'hFF, 1'b0, '{1'b1, ST_OK,          SIG_NONE, 1'b0, 8'h00}},
		'{REQ_MASTER_READ,  8'h00, 1'b1, '{1'b1, ST_HUNG_UP,     SIG_NONE, 1'b0, 8'h00}},
		'{REQ_SLAVE_OPEN,   8'h00, 1'b0, '{1'b1, ST_OK,          SIG_NONE, 1'b0, 8'h00}},
		// the three signal characters are consumed
		'{REQ_MASTER_WRITE, 8'h03, 1'b0, '{1'b1, ST_CONSUMED,    SIG_INT,  1'b0, 8'h00}},
		'{REQ_MASTER_WRITE, 8'h1C, 1'b1, '{1'b1, ST_CONSUMED,    SIG_QUIT, 1'b0, 8'h00}},
		'{REQ_MASTER_WRITE, 8'h1A, 1'b0, '{1'b1, ST_CONSUMED,    SIG_STOP, 1'b0, 8'h00}},
		// cr becomes nl on the way in, byte extremes pass untouched
		'{REQ_MASTER_WRITE, 8'h0D, 1'b0, '{1'b1, ST_OK,          SIG_NONE, 1'b0, 8'h00}},
		'{REQ_MASTER_WRITE, 8'hFF, 1'b1, '{1'b1, ST_OK,          SIG_NONE, 1'b0, 8'h00}},
		'{REQ_MASTER_WRITE, 8'h00, 1'b0, '{1'b1, ST_OK,          SIG_NONE, 1'b0, 8'h00}},
		'{REQ_SLAVE_READ,   8'h00, 1'b0, '{1'b1, ST_OK,          SIG_NONE, 1'b1, 8'h0A}},
		'{REQ_SLAVE_READ,   8'h00, 1'b1, '{1'b1, ST_OK,          SIG_NONE, 1'b1, 8'hFF}},
		'{REQ_SLAVE_READ,   8'h00, 1'b0, '{1'b1, ST_OK,          SIG_NONE, 1'b1, 8'h00}},
		// nl expands to cr nl on the way out, cr stays cr
		'{REQ_SLAVE_WRITE,  8'h0A, 1'b1, '{1'b1, ST_OK,          SIG_NONE, 1'b0, 8'h00}},
		'{REQ_SLAVE_WRITE,  8'h0D, 1'b0, '{1'b1, ST_OK,          SIG_NONE, 1'b0, 8'h00}},
		'{REQ_SLAVE_WRITE,  8'h55, 1'b0, NO_CHECK},
		'{REQ_MASTER_READ,  8'h00, 1'b0, '{1'b1, ST_OK,          SIG_NONE, 1'b1, 8'h0D}},
		'{REQ_MASTER_READ,  8'h00, 1'b0, '{1'b1, ST_OK,          SIG_NONE, 1'b1, 8'h0A}},
		'{REQ_MASTER_READ,  8'h00, 1'b1, '{1'b1, ST_OK,          SIG_NONE, 1'b1, 8'h0D}},
		'{REQ_MASTER_READ,  8'h00, 1'b0, NO_CHECK},
		// unused request codes change nothing
		'{REQ_RESERVED_A,   8'hFF, 1'b1, '{1'b1, ST_OK,          SIG_NONE, 1'b0, 8'h00}},
		'{REQ_RESERVED_B,   8'hAA, 1'b0, '{1'b1, ST_OK,          SIG_NONE, 1'b0, 8'h00}},
		// last opener leaves
		'{REQ_SLAVE_CLOSE,  8'h00, 1'b0, '{1'b1, ST_OK,          SIG_NONE, 1'b0, 8'h00}},
		'{REQ_MASTER_READ,  8'h00, 1'b1, '{1'b1, ST_HUNG_UP,     SIG_NONE, 1'b0, 8'h00}}
	};

	// register settings swept by the random part, extremes included
	localparam line_setting_t MODE_SWEEP [6] = '{
		// signals off, every cr/nl rule on
		'{1'b0, 3'd7, 3'd7, 8'h00, 8'hFF, 8'h0D},
		// ignore cr beats cr to nl, one char for all three signals
		'{1'b1, 3'd3, 3'd5, 8'h51, 8'h51, 8'h51},
		// cr raises interrupt, nl matches quit and suspend, output bits without enable
		'{1'b1, 3'd4, 3'd6, 8'h0D, 8'h0A, 8'h0A},
		'{1'b1, 3'd0, 3'd0, 8'hFF, 8'h00, 8'h80},
		'{1'b1, 3'd6, 3'd1, RST_INTERRUPT_CHAR, RST_QUIT_CHAR, RST_SUSPEND_CHAR},
		'{RST_SIGNAL_ENABLE, RST_INPUT_MODE, RST_OUTPUT_MODE, 8'h7F, 8'h80, 8'h20}
	};

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [2:0]           req_type     = '0;
	logic [7:0]           data_byte    = '0;
	logic                 last_in_call = 1'b0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [7:0]           read_byte;
	logic                 read_valid;
	logic [2:0]           status;
	logic [1:0]           signal_code;
	logic [LEVEL_W-1:0]   to_slave_level;
	logic [LEVEL_W-1:0]   to_master_level;
	logic                 hung_up;
	logic                 call_done;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;

	// pacing, percent of cycles spent idle or stalled
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	int mismatches   = 0;
	int results_seen = 0;

	// predicted results waiting for the block, and hand checks for items in flight
	line_result_t expected_results [$];
	hand_check_t  pending_checks [$];

	// shadow registers
	logic       sh_sig_en   = RST_SIGNAL_ENABLE;
	logic [2:0] sh_in_mode  = RST_INPUT_MODE;
	logic [2:0] sh_out_mode = RST_OUTPUT_MODE;
	logic [7:0] sh_intr     = RST_INTERRUPT_CHAR;
	logic [7:0] sh_quit     = RST_QUIT_CHAR;
	logic [7:0] sh_susp     = RST_SUSPEND_CHAR;

	// shadow rings; pointers wrap on their own since the depth is a power of two
	logic [7:0]       slave_bound_bytes [FIFO_DEPTH];
	logic [PTR_W-1:0] slave_bound_wr    = '0;
	logic [PTR_W-1:0] slave_bound_rd    = '0;
	int               slave_bound_count = 0;
	logic [7:0]       master_bound_bytes [FIFO_DEPTH];
	logic [PTR_W-1:0] master_bound_wr    = '0;
	logic [PTR_W-1:0] master_bound_rd    = '0;
	int               master_bound_count = 0;
	int               open_count         = 0;
	logic             hang_flag          = 1'b0;

	pseudo_terminal_byte_channel u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.data_byte       (data_byte),
		.last_in_call    (last_in_call),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.read_byte       (read_byte),
		.read_valid      (read_valid),
		.status          (status),
		.signal_code     (signal_code),
		.to_slave_level  (to_slave_level),
		.to_master_level (to_master_level),
		.hung_up         (hung_up),
		.call_done       (call_done),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// the run must end well before this
	initial begin : watchdog
		#10ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic void push_master_bound(logic [7:0] b);
		master_bound_bytes[master_bound_wr] = b;
		master_bound_wr++;
		master_bound_count++;
	endfunction

	// one request against the shadow state, returns the result it must give
	function automatic line_result_t predict_line_step(logic [2:0] req, logic [7:0] b_in,
			logic last);
		line_result_t r;
		logic [7:0]   b;
		logic         nl_crnl;
		logic         cr_nl;
		r = '0;
		b = b_in;
		r.status = ST_OK;
		r.sig = SIG_NONE;
		case (req)
			REQ_MASTER_WRITE: begin
				// interrupt, then quit, then suspend
				if (sh_sig_en && b == sh_intr) r.sig = SIG_INT;
				else if (sh_sig_en && b == sh_quit) r.sig = SIG_QUIT;
				else if (sh_sig_en && b == sh_susp) r.sig = SIG_STOP;
				if (r.sig != SIG_NONE) begin
					r.status = ST_CONSUMED;
				end else if (b == CHAR_CR && sh_in_mode[0]) begin
					r.status = ST_CONSUMED;
				end else begin
					if (b == CHAR_CR && sh_in_mode[1]) b = CHAR_NL;
					else if (b == CHAR_NL && sh_in_mode[2]) b = CHAR_CR;
					if (slave_bound_count < FIFO_DEPTH) begin
						slave_bound_bytes[slave_bound_wr] = b;
						slave_bound_wr++;
						slave_bound_count++;
					end else begin
						r.status = ST_DROPPED;
					end
				end
			end
			REQ_SLAVE_WRITE: begin
				// output rules only act with bit 0 set
				nl_crnl = sh_out_mode[0] && sh_out_mode[1];
				cr_nl = sh_out_mode[0] && sh_out_mode[2];
				if (b == CHAR_NL && nl_crnl) begin
					if (master_bound_count + 2 <= FIFO_DEPTH) begin
						push_master_bound(CHAR_CR);
						push_master_bound(CHAR_NL);
					end else begin
						r.status = ST_RETRY;
					end
				end else if (master_bound_count < FIFO_DEPTH) begin
					push_master_bound((b == CHAR_CR && cr_nl) ? CHAR_NL : b);
				end else begin
					r.status = ST_RETRY;
				end
			end
			REQ_MASTER_READ: begin
				if (master_bound_count > 0) begin
					r.rbyte = master_bound_bytes[master_bound_rd];
					r.rvalid = 1'b1;
					master_bound_rd++;
					master_bound_count--;
				end else begin
					r.status = hang_flag ? ST_HUNG_UP : ST_WOULD_BLOCK;
				end
			end
			REQ_SLAVE_READ: begin
				if (slave_bound_count > 0) begin
					r.rbyte = slave_bound_bytes[slave_bound_rd];
					r.rvalid = 1'b1;
					slave_bound_rd++;
					slave_bound_count--;
				end else begin
					r.status = ST_WOULD_BLOCK;
				end
			end
			REQ_SLAVE_OPEN: begin
				if (open_count < 255) open_count++;
				hang_flag = 1'b0;
			end
			REQ_SLAVE_CLOSE: begin
				if (open_count > 0) open_count--;
				if (open_count == 0) hang_flag = 1'b1;
			end
			default: ;
		endcase
		r.ts_lvl = LEVEL_W'(slave_bound_count);
		r.tm_lvl = LEVEL_W'(master_bound_count);
		r.hung = hang_flag;
		r.last = last;
		return r;
	endfunction

	task automatic log_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10) $display("%t %s", $realtime, msg);
	endtask

	// register writes, item acceptance, result checking and receiver stalls
	always @(posedge clk) begin : scoreboard
		line_result_t want;
		line_result_t got;
		hand_check_t  chk;
		out_stall <= ($urandom_range(99) < recv_stall_pct);
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SIGNAL_ENABLE:  sh_sig_en = cfg_data[0];
					CFG_INPUT_MODE:     sh_in_mode = cfg_data[2:0];
					CFG_OUTPUT_MODE:    sh_out_mode = cfg_data[2:0];
					CFG_INTERRUPT_CHAR: sh_intr = cfg_data;
					CFG_QUIT_CHAR:      sh_quit = cfg_data;
					CFG_SUSPEND_CHAR:   sh_susp = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				want = predict_line_step(req_type, data_byte, last_in_call);
				chk = pending_checks.pop_front();
				// directed rows carry their own expected status, signal, valid flag and byte
				if (chk.known) begin
					want.status = chk.status;
					want.sig = chk.sig;
					want.rvalid = chk.rvalid;
					want.rbyte = chk.rbyte;
				end
				expected_results.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = '{read_byte, read_valid, status, signal_code, to_slave_level,
					to_master_level, hung_up, call_done};
				if (expected_results.size() == 0) begin
					log_mismatch($sformatf("result %0d arrived with none expected", results_seen));
				end else begin
					want = expected_results.pop_front();
					if (got.rbyte !== want.rbyte || got.rvalid !== want.rvalid ||
							got.status !== want.status || got.sig !== want.sig ||
							got.ts_lvl !== want.ts_lvl || got.tm_lvl !== want.tm_lvl ||
							got.hung !== want.hung || got.last !== want.last)
						log_mismatch($sformatf({"result %0d: expected byte %h valid %b ",
							"status %0d sig %0d levels %0d/%0d hung %b done %b, got byte %h ",
							"valid %b status %0d sig %0d levels %0d/%0d hung %b done %b"},
							results_seen, want.rbyte, want.rvalid, want.status, want.sig,
							want.ts_lvl, want.tm_lvl, want.hung, want.last, got.rbyte,
							got.rvalid, got.status, got.sig, got.ts_lvl, got.tm_lvl,
							got.hung, got.last));
				end
				results_seen++;
			end
		end
	end

	task automatic set_pace(int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	// random idle cycles first, then hold the item until it is taken
	task automatic send_item(logic [2:0] req, logic [7:0] b, logic last, hand_check_t chk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		pending_checks.push_back(chk);
		in_valid <= 1'b1;
		req_type <= req;
		data_byte <= b;
		last_in_call <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// wait until every result is back, so registers can change safely
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(line_setting_t s);
		logic [CFG_IDX_W-1:0] idx [8];
		logic [CFG_W-1:0]     val [8];
		idx = '{CFG_SPARE_A, CFG_SIGNAL_ENABLE, CFG_INPUT_MODE, CFG_OUTPUT_MODE,
			CFG_INTERRUPT_CHAR, CFG_QUIT_CHAR, CFG_SUSPEND_CHAR, CFG_SPARE_B};
		// unused upper bits get random values
		val = '{8'($urandom), {7'($urandom), s.sig_en}, {5'($urandom), s.in_mode},
			{5'($urandom), s.out_mode}, s.intr_char, s.quit_char, s.susp_char,
			8'($urandom)};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// bias toward the bytes the line rules care about
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return CHAR_CR;
			1: return CHAR_NL;
			2: return sh_intr;
			3: return sh_quit;
			4: return sh_susp;
			5: return $urandom_range(1) ? 8'hFF : 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_random_item();
		int         pick;
		logic [2:0] req;
		pick = $urandom_range(99);
		if (pick < 30) req = REQ_MASTER_WRITE;
		else if (pick < 55) req = REQ_SLAVE_WRITE;
		else if (pick < 72) req = REQ_MASTER_READ;
		else if (pick < 90) req = REQ_SLAVE_READ;
		else if (pick < 94) req = REQ_SLAVE_OPEN;
		else if (pick < 98) req = REQ_SLAVE_CLOSE;
		else if (pick == 98) req = REQ_RESERVED_A;
		else req = REQ_RESERVED_B;
		send_item(req, pick_byte(), 1'($urandom), NO_CHECK);
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed items on reset register values
		set_pace(24, 24);
		foreach (DIRECTED_ROWS[i])
			send_item(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last,
				DIRECTED_ROWS[i].check);

		// random traffic under each setting, pacing rotates per phase
		for (int p = 0; p < 6; p++) begin
			settle();
			write_regs(MODE_SWEEP[p]);
			case (p % 4)
				0: set_pace(0, 0);
				1: set_pace(57, 0);
				2: set_pace(0, 57);
				default: set_pace(24, 24);
			endcase
			repeat (160) send_random_item();
		end

		// open count saturates at the top, then closes run it down to zero and hold it there
		settle();
		set_pace(24, 24);
		repeat (260) send_item(REQ_SLAVE_OPEN, 8'($urandom), 1'($urandom), NO_CHECK);
		repeat (258) send_item(REQ_SLAVE_CLOSE, 8'($urandom), 1'($urandom), NO_CHECK);
		repeat (2) send_item(REQ_MASTER_READ, 8'($urandom), 1'($urandom), NO_CHECK);

		// drain, then stay idle to catch stray results
		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ pseudo_terminal_byte_channel.f @@
+incdir+rtl/core
rtl/core/ptbc_pkg.sv
rtl/core/ptbc_ram.sv
rtl/core/ptbc_front.sv
rtl/core/ptbc_queue.sv
rtl/core/ptbc_back.sv
rtl/core/pseudo_terminal_byte_channel.sv
bench/tb_pseudo_terminal_byte_channel.sv
